// ----- design/telemetry_key_value_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// Telemetry key/value parser assertion macros
// Shared concurrent assertion forms used at the end of the core.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_KEY_VALUE_PARSER_CORE_DEFINES_SVH
`define TELEMETRY_KEY_VALUE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TKVP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TKVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tkvp_pkg.sv -----
// ----------------------------------------------------------------------------
// Telemetry key/value parser package
// Widths, character codes, result kinds and the key name table.
// ----------------------------------------------------------------------------
package tkvp_pkg;

    // text limits
    localparam int MAX_TEXT_BYTES = 511;
    localparam int BYTES_W        = $clog2(MAX_TEXT_BYTES + 1);

    // field widths
    localparam int BYTE_W     = 8;
    localparam int FIELD_ID_W = 4;
    localparam int VALUE_W    = 32;
    localparam int KEY_MAX    = 5;
    localparam int KEY_BITS   = KEY_MAX * BYTE_W;
    localparam int KEY_LEN_W  = 3;
    localparam int NUM_KEYS   = 12;

    // key length code for a key that is too long to match
    localparam logic [KEY_LEN_W-1:0] KEY_TOO_LONG = 3'd6;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // result kinds
    typedef enum logic
    {
        RK_FIELD  = 1'b0,
        RK_RECORD = 1'b1
    } result_kind_t;

    // one result item
    typedef struct packed
    {
        result_kind_t                 kind;
        logic [FIELD_ID_W-1:0]        id;
        logic signed [VALUE_W-1:0]    value;
        logic                         last;
    } result_t;

    // key lookup outcome
    typedef struct packed
    {
        logic                  hit;
        logic [FIELD_ID_W-1:0] id;
    } key_match_t;

    // key names, packed with the last character in the low byte
    localparam logic [KEY_BITS-1:0] KEY_CHARS [NUM_KEYS] = '{
        40'h0000626174,  // bat
        40'h0000000068,  // h
        40'h0074696D65,  // time
        40'h7069746368,  // pitch
        40'h00726F6C6C,  // roll
        40'h0000796177,  // yaw
        40'h0000766778,  // vgx
        40'h0000766779,  // vgy
        40'h000076677A,  // vgz
        40'h74656D706C,  // templ
        40'h74656D7068,  // temph
        40'h0000746F66   // tof
    };

    localparam logic [KEY_LEN_W-1:0] KEY_LENS [NUM_KEYS] = '{
        3'd3, 3'd1, 3'd4, 3'd5, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd3
    };

    // compare a collected key against all names in parallel
    function automatic key_match_t key_lookup(
        input logic [KEY_BITS-1:0]  chars,
        input logic [KEY_LEN_W-1:0] len
    );
        key_match_t m;
        m.hit = 1'b0;
        m.id  = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (len == KEY_LENS[i] && chars == KEY_CHARS[i])
            begin
                m.hit = 1'b1;
                m.id  = FIELD_ID_W'(i);
            end
        end
        return m;
    endfunction

endpackage

// ----- design/telemetry_key_value_parser_core.sv -----
// ----------------------------------------------------------------------------
// Telemetry key/value parser core
// Splits datagram text into key:value tokens and emits one result per known
// key plus a record-complete result at the end of each datagram.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  text      in         text_valid / text_ready     text_byte, end_of_packet
//  result    out        result_valid / result_ready result_kind, field_id,
//                                                   field_value, last_of_run
//
//  One byte per cycle: a byte is parsed in the cycle after it is taken into
//  the input register, and its results land in a two-entry result queue.
//  The input register moves on when the queue has room for all results of
//  its byte (at most two, on the final byte of a datagram), counting a result
//  that leaves in the same cycle, so a stalled result side holds the text
//  side once a byte with results finds the queue full.
//  rst_n clears the parser to the start of a datagram and empties the queue.
//
`include "telemetry_key_value_parser_core_defines.svh"

module telemetry_key_value_parser_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // text channel
    input  logic                                 text_valid,
    output logic                                 text_ready,
    input  logic [tkvp_pkg::BYTE_W-1:0]          text_byte,
    input  logic                                 end_of_packet,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic                                 result_kind,
    output logic [tkvp_pkg::FIELD_ID_W-1:0]      field_id,
    output logic signed [tkvp_pkg::VALUE_W-1:0]  field_value,
    output logic                                 last_of_run
);
    import tkvp_pkg::*;

    // token parse phases
    typedef enum logic [2:0]
    {
        PH_KEY_START = 3'd0,
        PH_KEY       = 3'd1,
        PH_VAL_WS    = 3'd2,
        PH_VAL_DIG   = 3'd3,
        PH_SKIP      = 3'd4,
        PH_VAL_DONE  = 3'd5
    } phase_t;

    // state of the open token
    typedef struct packed
    {
        phase_t                 phase;
        logic [KEY_BITS-1:0]    key_chars;
        logic [KEY_LEN_W-1:0]   key_length;
        logic [VALUE_W-1:0]     acc;
        logic                   negative;
    } token_t;

    localparam token_t TOKEN_CLEAR = '{
        phase:      PH_KEY_START,
        key_chars:  '0,
        key_length: '0,
        acc:        '0,
        negative:   1'b0
    };

    localparam logic [VALUE_W-1:0] MAG_CAP = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // registers
    logic                 stage_valid_reg;
    logic [BYTE_W-1:0]    stage_byte_reg;
    logic                 stage_eop_reg;
    token_t               tok_reg;
    logic [BYTES_W-1:0]   seen_reg;
    logic                 ended_reg;
    result_t              q_reg [2];
    logic [1:0]           q_cnt_reg;

    // next values
    token_t               tok_next;
    logic [BYTES_W-1:0]   seen_next;
    logic                 ended_next;
    result_t              q_next [2];
    logic [1:0]           q_cnt_next;

    // parse signals
    token_t               tok_byte;
    token_t               fin_tok;
    logic                 byte_fin;
    logic                 fin_do;
    logic                 ended_mid;
    key_match_t           look;
    logic                 field_hit;
    logic [VALUE_W-1:0]   field_val;
    result_t              res0;
    result_t              res1;
    logic [1:0]           n_res;
    logic                 advance;
    logic                 pop;
    result_t              q0_pop;
    result_t              q1_pop;
    logic [1:0]           cnt_pop;

    // accumulate one decimal digit, saturating at 2^31
    function automatic logic [VALUE_W-1:0] add_digit(
        input logic [VALUE_W-1:0] acc,
        input logic [BYTE_W-1:0]  c
    );
        logic [VALUE_W+3:0] m;
        m = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_W+4)'(c - CH_ZERO);
        return (m >= (VALUE_W+4)'(MAG_CAP)) ? MAG_CAP : m[VALUE_W-1:0];
    endfunction

    // one non-separator byte applied to the open token
    function automatic token_t take_byte(
        input token_t            t,
        input logic [BYTE_W-1:0] c
    );
        token_t r;
        logic   in_key;
        r      = t;
        in_key = 1'b0;
        case (t.phase)
            PH_KEY_START:
            begin
                if (c != CH_SPACE)
                begin
                    r.phase = PH_KEY;
                    in_key  = 1'b1;
                end
            end
            PH_KEY:
            begin
                in_key = 1'b1;
            end
            PH_VAL_WS:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                begin
                    r.phase = PH_VAL_WS;
                end
                else if (c == CH_MINUS)
                begin
                    r.negative = 1'b1;
                    r.phase    = PH_VAL_DIG;
                end
                else if (c == CH_PLUS)
                begin
                    r.phase = PH_VAL_DIG;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    r.acc   = add_digit(t.acc, c);
                    r.phase = PH_VAL_DIG;
                end
                else
                begin
                    r.phase = PH_VAL_DONE;
                end
            end
            PH_VAL_DIG:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    r.acc = add_digit(t.acc, c);
                end
                else
                begin
                    r.phase = PH_VAL_DONE;
                end
            end
            default:
            begin
                r = t;
            end
        endcase
        // key collection, shared by key start and key phases
        if (in_key)
        begin
            if (c == CH_COLON)
            begin
                r.phase = PH_VAL_WS;
            end
            else if (t.key_length < KEY_LEN_W'(KEY_MAX))
            begin
                r.key_chars  = {t.key_chars[KEY_BITS-BYTE_W-1:0], c};
                r.key_length = t.key_length + 1'b1;
            end
            else
            begin
                r.key_length = KEY_TOO_LONG;
            end
        end
        return r;
    endfunction

    // byte intake and text end
    always_comb
    begin
        tok_byte  = tok_reg;
        ended_mid = ended_reg;
        seen_next = seen_reg;
        byte_fin  = 1'b0;
        if (!ended_reg)
        begin
            if (stage_byte_reg == CH_NUL || seen_reg >= BYTES_W'(MAX_TEXT_BYTES))
            begin
                byte_fin  = 1'b1;
                ended_mid = 1'b1;
            end
            else
            begin
                seen_next = seen_reg + 1'b1;
                if (stage_byte_reg == CH_SEMI)
                begin
                    byte_fin = 1'b1;
                end
                else
                begin
                    tok_byte = take_byte(tok_reg, stage_byte_reg);
                end
            end
        end
        // byte count starts over with the next datagram
        if (stage_eop_reg)
        begin
            seen_next = '0;
        end
    end

    // token finish: a byte that ends a token finishes the old token,
    // otherwise the end of packet finishes the updated one
    always_comb
    begin
        fin_tok   = byte_fin ? tok_reg : tok_byte;
        fin_do    = byte_fin || (stage_eop_reg && !ended_mid);
        look      = key_lookup(fin_tok.key_chars, fin_tok.key_length);
        field_hit = fin_do && look.hit &&
                    (fin_tok.phase == PH_VAL_WS || fin_tok.phase == PH_VAL_DIG ||
                     fin_tok.phase == PH_VAL_DONE);
        if (fin_tok.negative)
        begin
            field_val = '0 - fin_tok.acc;
        end
        else
        begin
            field_val = fin_tok.acc[VALUE_W-1] ? POS_MAX : fin_tok.acc;
        end
        tok_next   = fin_do ? TOKEN_CLEAR : tok_byte;
        ended_next = ended_mid;
        if (stage_eop_reg)
        begin
            tok_next   = TOKEN_CLEAR;
            ended_next = 1'b0;
        end
    end

    // results of the staged byte
    always_comb
    begin
        n_res = {1'b0, field_hit} + {1'b0, stage_eop_reg};
        res1  = '{kind: RK_RECORD, id: '0, value: '0, last: 1'b1};
        if (field_hit)
        begin
            res0 = '{kind: RK_FIELD, id: look.id, value: field_val, last: !stage_eop_reg};
        end
        else
        begin
            res0 = res1;
        end
    end

    // flow control, a result leaving this cycle frees its slot
    assign pop        = result_valid && result_ready;
    assign advance    = stage_valid_reg &&
                        (({1'b0, n_res} + {1'b0, q_cnt_reg}) <= (3'd2 + {2'b0, pop}));
    assign text_ready = !stage_valid_reg || advance;

    // result queue: pop at the head, then append
    always_comb
    begin
        if (pop)
        begin
            q0_pop  = q_reg[1];
            q1_pop  = q_reg[1];
            cnt_pop = q_cnt_reg - 1'b1;
        end
        else
        begin
            q0_pop  = q_reg[0];
            q1_pop  = q_reg[1];
            cnt_pop = q_cnt_reg;
        end
        q_next[0]  = q0_pop;
        q_next[1]  = q1_pop;
        q_cnt_next = cnt_pop;
        if (advance && n_res != 2'd0)
        begin
            q_cnt_next = cnt_pop + n_res;
            if (cnt_pop == 2'd0)
            begin
                q_next[0] = res0;
            end
            else
            begin
                q_next[1] = res0;
            end
            if (n_res == 2'd2)
            begin
                q_next[1] = res1;
            end
        end
    end

    // output drive from the queue head
    assign result_valid = (q_cnt_reg != 2'd0);
    assign result_kind  = q_reg[0].kind;
    assign field_id     = q_reg[0].id;
    assign field_value  = q_reg[0].value;
    assign last_of_run  = q_reg[0].last;

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_byte_reg  <= '0;
            stage_eop_reg   <= 1'b0;
            tok_reg         <= TOKEN_CLEAR;
            seen_reg        <= '0;
            ended_reg       <= 1'b0;
            q_reg[0]        <= '0;
            q_reg[1]        <= '0;
            q_cnt_reg       <= '0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                stage_valid_reg <= 1'b1;
                stage_byte_reg  <= text_byte;
                stage_eop_reg   <= end_of_packet;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                tok_reg   <= tok_next;
                seen_reg  <= seen_next;
                ended_reg <= ended_next;
            end
            q_reg[0]  <= q_next[0];
            q_reg[1]  <= q_next[1];
            q_cnt_reg <= q_cnt_next;
        end
    end

    // assertions
    `TKVP_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, q_cnt_reg <= 2'd2, "result queue overfilled")
    `TKVP_ASSERT_NEXT(a_result_shown, clk, rst_n, advance && n_res != 2'd0, result_valid, "parsed result not presented")
    `TKVP_ASSERT_SAME(a_record_shape, clk, rst_n, result_valid && result_kind == RK_RECORD, last_of_run && field_id == '0 && field_value == '0, "malformed record-complete result")
    `TKVP_ASSERT_NEXT(a_stage_hold, clk, rst_n, stage_valid_reg && !advance, stage_valid_reg && $stable(stage_byte_reg) && $stable(stage_eop_reg), "stalled byte lost")

endmodule
